// ===== hw/rtl/lmts_pkg.sv =====
// Shared types, constants and decision functions for the lock motor travel sequencer.
// Used by lmts_cfg, lmts_seq and lock_motor_travel_sequencer_top; depends on nothing.
`default_nettype none

package lmts_pkg;

  // Datapath sizes.
  localparam int SENSE_BITS  = 12;
  localparam int COUNT_BITS  = 16;
  localparam int TICK_BITS   = 16;
  localparam int THR_BITS    = 9;
  localparam int SCALED_BITS = 9;
  localparam int PROD_BITS   = SENSE_BITS + SCALED_BITS;
  localparam int CMP_BITS    = (COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS;
  localparam int SCALE_MUL   = 280;

  // APB register map.
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_BLANK     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;
  localparam logic [1:0] REG_HOLD      = 2'd3;

  localparam logic [THR_BITS-1:0]  RST_THRESHOLD = THR_BITS'(140);
  localparam logic [TICK_BITS-1:0] RST_BLANK     = TICK_BITS'(500);
  localparam logic [TICK_BITS-1:0] RST_TIMEOUT   = TICK_BITS'(10000);

  // Phase codes.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_RA    = 3'd2;
  localparam logic [2:0] PH_RB    = 3'd3;
  localparam logic [2:0] PH_RC    = 3'd4;
  localparam logic [2:0] PH_LW    = 3'd5;

  // Sequence stages.
  localparam logic [1:0] ST_A   = 2'd0;
  localparam logic [1:0] ST_B   = 2'd1;
  localparam logic [1:0] ST_C   = 2'd2;
  localparam logic [1:0] ST_END = 2'd3;

  // Drive codes.
  localparam logic [1:0] DRV_OPEN  = 2'd0;
  localparam logic [1:0] DRV_RAISE = 2'd1;
  localparam logic [1:0] DRV_LOWER = 2'd2;
  localparam logic [1:0] DRV_BRAKE = 2'd3;

  // Position codes.
  localparam logic [1:0] POS_RAISED  = 2'd0;
  localparam logic [1:0] POS_LOWERED = 2'd1;
  localparam logic [1:0] POS_TRAVEL  = 2'd2;

  // Beep codes.
  localparam logic [1:0] BEEP_NONE   = 2'd0;
  localparam logic [1:0] BEEP_TRIPLE = 2'd1;
  localparam logic [1:0] BEEP_SINGLE = 2'd2;

  typedef struct packed {
    logic [THR_BITS-1:0]  stall_threshold;
    logic [TICK_BITS-1:0] blank_ticks;
    logic [TICK_BITS-1:0] timeout_ticks;
    logic                 hold_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0] drive;
    logic       ir_enable;
    logic       busy_res;
    logic       finished;
    logic       failed;
    logic [1:0] beep;
  } res_t;

  function automatic logic [1:0] phase_dir(input logic [2:0] p);
    phase_dir = (p == PH_RB || p == PH_RC) ? DRV_RAISE : DRV_LOWER;
  endfunction

  function automatic logic phase_holds(input logic [2:0] p, input logic [1:0] pos);
    case (p)
      PH_RA:   phase_holds = (pos == POS_RAISED);
      PH_RB:   phase_holds = (pos == POS_LOWERED);
      PH_RC:   phase_holds = (pos == POS_TRAVEL);
      default: phase_holds = (pos != POS_LOWERED);
    endcase
  endfunction

  // Next phase of a goal's sequence from a stage; PH_IDLE means the run is done.
  function automatic logic [2:0] select_phase(input logic goal, input logic [1:0] stage,
                                              input logic [1:0] pos);
    if (goal) begin
      select_phase = (stage == ST_A && pos != POS_LOWERED) ? PH_LW : PH_IDLE;
    end else if (stage == ST_A && pos == POS_RAISED) begin
      select_phase = PH_RA;
    end else if (stage <= ST_B && pos == POS_LOWERED) begin
      select_phase = PH_RB;
    end else if (stage <= ST_C && pos == POS_TRAVEL) begin
      select_phase = PH_RC;
    end else begin
      select_phase = PH_IDLE;
    end
  endfunction

  function automatic logic [1:0] stage_after(input logic [2:0] p);
    case (p)
      PH_RA:   stage_after = ST_B;
      PH_RB:   stage_after = ST_C;
      default: stage_after = ST_END;
    endcase
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lmts_cfg.sv =====
// APB configuration register file for the lock motor travel sequencer.
// Depends on lmts_pkg for the register map, widths and reset values.
`default_nettype none

module lmts_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lmts_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [lmts_pkg::DATA_BITS-1:0] pwdata,
  output logic      [lmts_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready,
  output lmts_pkg::cfg_t                     cfg
);

  lmts_pkg::cfg_t cfg_r;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stall_threshold <= lmts_pkg::RST_THRESHOLD;
      cfg_r.blank_ticks     <= lmts_pkg::RST_BLANK;
      cfg_r.timeout_ticks   <= lmts_pkg::RST_TIMEOUT;
      cfg_r.hold_mode       <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        lmts_pkg::REG_THRESHOLD: cfg_r.stall_threshold <= pwdata[lmts_pkg::THR_BITS-1:0];
        lmts_pkg::REG_BLANK:     cfg_r.blank_ticks     <= pwdata[lmts_pkg::TICK_BITS-1:0];
        lmts_pkg::REG_TIMEOUT:   cfg_r.timeout_ticks   <= pwdata[lmts_pkg::TICK_BITS-1:0];
        lmts_pkg::REG_HOLD:      cfg_r.hold_mode       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lmts_pkg::REG_THRESHOLD: prdata = lmts_pkg::DATA_BITS'(cfg_r.stall_threshold);
      lmts_pkg::REG_BLANK:     prdata = lmts_pkg::DATA_BITS'(cfg_r.blank_ticks);
      lmts_pkg::REG_TIMEOUT:   prdata = lmts_pkg::DATA_BITS'(cfg_r.timeout_ticks);
      lmts_pkg::REG_HOLD:      prdata = lmts_pkg::DATA_BITS'(cfg_r.hold_mode);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lmts_seq.sv =====
// Run sequencer: phase state, blanking and timeout counters, and the per-item decision.
// Depends on lmts_pkg for phase codes, decision functions and the cfg_t/res_t types.
`default_nettype none

module lmts_seq (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             adv,
  input  wire logic                             op,
  input  wire logic                             target,
  input  wire logic [1:0]                       pos,
  input  wire logic [lmts_pkg::SCALED_BITS-1:0] scaled,
  input  wire lmts_pkg::cfg_t                   cfg,
  output lmts_pkg::res_t                        res
);

  logic [2:0]                     phase_r, phase_nxt;
  logic                           goal_r, goal_nxt;
  logic [lmts_pkg::COUNT_BITS-1:0] blank_r, blank_nxt;
  logic [lmts_pkg::COUNT_BITS-1:0] abort_r, abort_nxt;
  logic                           moved_r, moved_nxt;
  logic [1:0]                     drive_r, drive_nxt;

  always_comb begin
    logic [2:0] nx;
    logic       timed_out;
    logic       stall;
    logic       ok_end;
    logic       err_end;
    logic       enter;
    logic       braked;

    phase_nxt = phase_r;
    goal_nxt  = goal_r;
    blank_nxt = blank_r;
    abort_nxt = abort_r;
    moved_nxt = moved_r;
    drive_nxt = drive_r;
    nx        = lmts_pkg::PH_IDLE;
    timed_out = 1'b0;
    stall     = 1'b0;
    ok_end    = 1'b0;
    err_end   = 1'b0;
    enter     = 1'b0;
    braked    = 1'b0;
    res       = '0;

    if (op) begin
      goal_nxt  = target;
      phase_nxt = lmts_pkg::PH_START;
      abort_nxt = '0;
      blank_nxt = '0;
      moved_nxt = 1'b0;
      drive_nxt = lmts_pkg::DRV_OPEN;
    end else if (phase_r != lmts_pkg::PH_IDLE && phase_r <= lmts_pkg::PH_LW) begin
      timed_out = lmts_pkg::CMP_BITS'(abort_r) >= lmts_pkg::CMP_BITS'(cfg.timeout_ticks);
      abort_nxt = lmts_pkg::sat_inc(abort_r);
      if (phase_r == lmts_pkg::PH_START) begin
        nx    = lmts_pkg::select_phase(goal_r, lmts_pkg::ST_A, pos);
        enter = 1'b1;
      end else if (lmts_pkg::phase_holds(phase_r, pos)) begin
        stall = (lmts_pkg::CMP_BITS'(blank_r) >= lmts_pkg::CMP_BITS'(cfg.blank_ticks)) &&
                (scaled > cfg.stall_threshold);
        blank_nxt = lmts_pkg::sat_inc(blank_r);
        if (stall) begin
          if (cfg.hold_mode || phase_r == lmts_pkg::PH_RA) begin
            err_end = 1'b1;
          end else begin
            // Reversal restarts the opposite goal's sequence on this tick.
            goal_nxt = ~goal_r;
            nx       = lmts_pkg::select_phase(~goal_r, lmts_pkg::ST_A, pos);
            enter    = 1'b1;
          end
        end else if (timed_out) begin
          err_end = 1'b1;
        end else begin
          drive_nxt = lmts_pkg::phase_dir(phase_r);
        end
      end else begin
        nx     = lmts_pkg::select_phase(goal_r, lmts_pkg::stage_after(phase_r), pos);
        enter  = 1'b1;
        braked = 1'b1;
      end

      if (enter) begin
        if (nx != lmts_pkg::PH_IDLE) begin
          phase_nxt = nx;
          blank_nxt = '0;
          moved_nxt = 1'b1;
          drive_nxt = braked ? lmts_pkg::DRV_BRAKE : lmts_pkg::phase_dir(nx);
        end else begin
          ok_end = 1'b1;
        end
      end
    end else begin
      phase_nxt = lmts_pkg::PH_IDLE;
      drive_nxt = lmts_pkg::DRV_OPEN;
    end

    if (ok_end || err_end) begin
      res.finished = 1'b1;
      res.failed   = err_end;
      if (ok_end && !(cfg.hold_mode && !moved_nxt)) begin
        res.beep = goal_nxt ? lmts_pkg::BEEP_SINGLE : lmts_pkg::BEEP_TRIPLE;
      end
      phase_nxt = lmts_pkg::PH_IDLE;
      drive_nxt = lmts_pkg::DRV_OPEN;
    end

    res.drive     = drive_nxt;
    res.ir_enable = (phase_nxt != lmts_pkg::PH_IDLE);
    res.busy_res  = (phase_nxt != lmts_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lmts_pkg::PH_IDLE;
      goal_r  <= 1'b0;
      blank_r <= '0;
      abort_r <= '0;
      moved_r <= 1'b0;
      drive_r <= lmts_pkg::DRV_OPEN;
    end else if (adv) begin
      phase_r <= phase_nxt;
      goal_r  <= goal_nxt;
      blank_r <= blank_nxt;
      abort_r <= abort_nxt;
      moved_r <= moved_nxt;
      drive_r <= drive_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lock_motor_travel_sequencer_top.sv =====
// Top level of the lock motor travel sequencer: input register, result register, APB port.
// Depends on lmts_pkg, lmts_cfg and lmts_seq.
//
//   Channel   Direction  Handshake            Payload
//   in_       in         in_valid / in_stall  op, target, position, sense_raw
//   out_      out        out_valid/out_stall  drive, ir_enable, busy_res, finished, failed, beep
//   APB       in/out     psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// One item is taken per clock cycle while in_stall is low. An accepted item lands in the input
// register, where the current-sense sample is already scaled by 280/4096 with one small
// multiplier; when the result register is free or being emptied by a transfer, the sequencer
// decides and the result register loads.
// The sequencer state updates in the same cycle the result register loads.
// Reset is synchronous and active low: it clears both valid flags, the sequencer state and
// restores the register defaults. A stall on the result side holds the result register and,
// once the input register is also full, raises in_stall in the same cycle.
`default_nettype none

module lock_motor_travel_sequencer_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input channel.
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_op,
  input  wire logic                             in_target,
  input  wire logic [1:0]                       in_position,
  input  wire logic [lmts_pkg::SENSE_BITS-1:0]  in_sense_raw,
  // Result channel.
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            out_drive,
  output logic                                  out_ir_enable,
  output logic                                  out_busy_res,
  output logic                                  out_finished,
  output logic                                  out_failed,
  output logic [1:0]                            out_beep,
  // Configuration port.
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lmts_pkg::ADDR_BITS-1:0]   paddr,
  input  wire logic [lmts_pkg::DATA_BITS-1:0]   pwdata,
  output logic      [lmts_pkg::DATA_BITS-1:0]   prdata,
  output logic                                  pready
);

  lmts_pkg::cfg_t cfg;
  lmts_pkg::res_t res;
  lmts_pkg::res_t res_r;

  // Input register.
  logic                             in_vld_r, in_vld_nxt;
  logic                             op_r;
  logic                             target_r;
  logic [1:0]                       pos_r;
  logic [lmts_pkg::SCALED_BITS-1:0] scaled_r, scaled_nxt;
  logic [lmts_pkg::PROD_BITS-1:0]   prod;

  // Result register valid.
  logic out_vld_r, out_vld_nxt;

  logic adv;
  logic in_fire;

  // The decision stage advances when it holds an item and the result register is free
  // or being emptied by a transfer in this cycle.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_fire  = in_valid && !in_stall;

  // Scaled level is floor(raw * 280 / 2^SENSE_BITS), which always fits in nine bits.
  assign prod       = lmts_pkg::PROD_BITS'(in_sense_raw) *
                      lmts_pkg::PROD_BITS'(lmts_pkg::SCALE_MUL);
  assign scaled_nxt = prod[lmts_pkg::PROD_BITS-1:lmts_pkg::SENSE_BITS];

  assign in_vld_nxt  = in_fire ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_stall ? out_vld_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers carry no reset; they only load alongside a transfer.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_op;
      target_r <= in_target;
      pos_r    <= in_position;
      scaled_r <= scaled_nxt;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  lmts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lmts_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .op     (op_r),
    .target (target_r),
    .pos    (pos_r),
    .scaled (scaled_r),
    .cfg    (cfg),
    .res    (res)
  );

  assign out_valid     = out_vld_r;
  assign out_drive     = res_r.drive;
  assign out_ir_enable = res_r.ir_enable;
  assign out_busy_res  = res_r.busy_res;
  assign out_finished  = res_r.finished;
  assign out_failed    = res_r.failed;
  assign out_beep      = res_r.beep;

endmodule

`default_nettype wire
